### hdl/assert_macros.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LNEC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define LNEC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/lnec_pkg.sv
// Types and constants of the nested envelope chain block.
package lnec_pkg;

  localparam int DIM_W = 20;
  localparam int POS_W = 7;
  localparam int KEY_W = 2 * DIM_W + POS_W;

  // Configuration register indexes
  localparam logic [0:0] REG_CARD_W = 1'b0;
  localparam logic [0:0] REG_CARD_H = 1'b1;

  // Envelope token that circulates around the ring of cells
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pred;
  } tok_t;

  // Control strobes from the sequencer to every cell
  typedef struct packed {
    logic init;
    logic tok_load;
    logic shift;
    logic cmp;
    logic upd;
  } cell_ctrl_t;

endpackage

### hdl/lnec_cell.sv
// One envelope cell: holds an envelope, its chain length and predecessor.
module lnec_cell (
  input  logic                            clk,
  input  lnec_pkg::cell_ctrl_t            ctrl,
  input  logic                            wr,
  input  logic [lnec_pkg::DIM_W-1:0]      wr_width,
  input  logic [lnec_pkg::DIM_W-1:0]      wr_height,
  input  logic [lnec_pkg::DIM_W-1:0]      card_width,
  input  logic [lnec_pkg::DIM_W-1:0]      card_height,
  input  logic [lnec_pkg::POS_W-1:0]      count,
  input  logic [lnec_pkg::POS_W-1:0]      cell_idx,
  input  lnec_pkg::tok_t                  tok_in,
  output lnec_pkg::tok_t                  tok_out
);

  logic [lnec_pkg::DIM_W-1:0] width;
  logic [lnec_pkg::DIM_W-1:0] height;
  logic [lnec_pkg::POS_W-1:0] len;
  logic [lnec_pkg::POS_W-1:0] pred;
  lnec_pkg::tok_t             tok;
  logic [lnec_pkg::POS_W-1:0] blen;
  logic [lnec_pkg::KEY_W-1:0] bkey;

  logic elig;
  logic cand;
  logic better;

  // Envelope takes part when loaded in this set and larger than the card
  assign elig = (cell_idx < count) && (width > card_width) && (height > card_height);

  // Token is a possible predecessor when it fits strictly inside
  assign cand = (tok.len != '0) && (tok.w < width) && (tok.h < height);

  // Prefer longer chains, then the earlier envelope in sort order
  assign better = (tok.len > blen) ||
                  ((tok.len == blen) && ({tok.w, tok.h, tok.idx} < bkey));

  assign tok_out = tok;

  always_ff @(posedge clk) begin
    if (wr) begin
      width  <= wr_width;
      height <= wr_height;
    end
    if (ctrl.init) begin
      len  <= elig ? lnec_pkg::POS_W'(1) : '0;
      pred <= '0;
    end else if (ctrl.upd) begin
      len  <= elig ? lnec_pkg::POS_W'(blen + lnec_pkg::POS_W'(1)) : '0;
      pred <= (elig && blen != '0) ?
              lnec_pkg::POS_W'(bkey[lnec_pkg::POS_W-1:0] + lnec_pkg::POS_W'(1)) : '0;
    end
    // Load own token or pass the neighbor's along
    if (ctrl.tok_load) begin
      tok.w    <= width;
      tok.h    <= height;
      tok.idx  <= cell_idx;
      tok.len  <= len;
      tok.pred <= pred;
      blen     <= '0;
    end else if (ctrl.shift) begin
      tok <= tok_in;
      if (ctrl.cmp && cand && better) begin
        blen <= tok.len;
        bkey <= {tok.w, tok.h, tok.idx};
      end
    end
  end

endmodule

### hdl/longest_nested_envelope_chain_top.sv
// Top level of the longest nested envelope chain block.
//
// Envelopes arrive on the env channel (env_valid/env_stall), one per
// transaction, one per cycle while loading. The transaction with is_last
// set closes the set; envelopes beyond MAX_ITEMS are dropped. The block
// then stalls env and computes chain lengths on a ring of MAX_ITEMS cells:
// each pass loads every cell's token and rotates it once around the ring,
// and n passes run for n loaded envelopes. One more rotation finds the
// chain end, and the trace walks predecessors around the ring, pushing
// each member on a stack. Each result is then read from the stack in S_RD
// and shown in S_SHOW on the res channel, smallest envelope first, with
// last_of_run on the final one. An empty chain gives one result with zero
// length and position. The result is held while res_stall is high. Reset
// clears the control state, the load count and the card registers; card
// registers must be written through cfg_we/cfg_index/cfg_data only while
// the block is idle, which the block itself does not enforce.
module longest_nested_envelope_chain_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lnec_pkg::DIM_W-1:0]  cfg_data,
  input  logic                        env_valid,
  output logic                        env_stall,
  input  logic [lnec_pkg::DIM_W-1:0]  env_width,
  input  logic [lnec_pkg::DIM_W-1:0]  env_height,
  input  logic                        is_last,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [lnec_pkg::POS_W-1:0]  chain_length,
  output logic [lnec_pkg::POS_W-1:0]  envelope_position,
  output logic                        last_of_run
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [lnec_pkg::POS_W-1:0] LAST_CYC = lnec_pkg::POS_W'(MAX_ITEMS - 1);
  localparam logic [lnec_pkg::POS_W-1:0] FULL = lnec_pkg::POS_W'(MAX_ITEMS);

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_INIT  = 10'b0000000010,
    S_PLOAD = 10'b0000000100,
    S_PCMP  = 10'b0000001000,
    S_PUPD  = 10'b0000010000,
    S_FLOAD = 10'b0000100000,
    S_FSCAN = 10'b0001000000,
    S_TRACE = 10'b0010000000,
    S_RD    = 10'b0100000000,
    S_SHOW  = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [lnec_pkg::DIM_W-1:0] card_width;
  logic [lnec_pkg::DIM_W-1:0] card_height;
  logic [lnec_pkg::POS_W-1:0] loaded_count;
  logic [lnec_pkg::POS_W-1:0] count;
  logic [lnec_pkg::POS_W-1:0] pass;
  logic [lnec_pkg::POS_W-1:0] cyc;
  logic [lnec_pkg::POS_W-1:0] bl;
  logic [lnec_pkg::KEY_W-1:0] bkey;
  logic [lnec_pkg::POS_W-1:0] cur;
  logic [lnec_pkg::POS_W-1:0] sp;
  logic [lnec_pkg::POS_W-1:0] rdp;
  logic [lnec_pkg::POS_W-1:0] total;
  logic [lnec_pkg::POS_W-1:0] rdata;
  logic [lnec_pkg::POS_W-1:0] stack [MAX_ITEMS];

  lnec_pkg::cell_ctrl_t ctrl;
  lnec_pkg::tok_t       tok_arr [MAX_ITEMS];
  lnec_pkg::tok_t       tap;

  logic accept;
  logic store_ok;
  logic take;
  logic match;
  logic push;
  logic emit_done;
  logic [lnec_pkg::POS_W-1:0] fin_len;
  logic [lnec_pkg::POS_W-1:0] fin_idx;
  logic [lnec_pkg::POS_W-1:0] rd_sel;

  assign env_stall = (state != S_LOAD);
  assign accept    = env_valid && !env_stall;
  assign store_ok  = (loaded_count < FULL);
  assign tap       = tok_arr[MAX_ITEMS-1];

  // Sequencer strobes to the cell row
  always_comb begin
    ctrl          = '0;
    ctrl.init     = (state == S_INIT);
    ctrl.tok_load = (state == S_PLOAD) || (state == S_FLOAD);
    ctrl.shift    = (state == S_PCMP) || (state == S_FSCAN) || (state == S_TRACE);
    ctrl.cmp      = (state == S_PCMP);
    ctrl.upd      = (state == S_PUPD);
  end

  // Row of cells joined into a ring
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    lnec_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .wr          (accept && store_ok && (loaded_count == lnec_pkg::POS_W'(k))),
      .wr_width    (env_width),
      .wr_height   (env_height),
      .card_width  (card_width),
      .card_height (card_height),
      .count       (count),
      .cell_idx    (lnec_pkg::POS_W'(k)),
      .tok_in      (tok_arr[(k == 0) ? (MAX_ITEMS - 1) : (k - 1)]),
      .tok_out     (tok_arr[k])
    );
  end

  // Chain end search at the ring tap
  assign take = (tap.len > bl) || ((tap.len == bl) && ({tap.w, tap.h, tap.idx} < bkey));
  assign fin_len = take ? tap.len : bl;
  assign fin_idx = take ? tap.idx : bkey[lnec_pkg::POS_W-1:0];

  // Trace: the tap carries the current member
  assign match  = (state == S_TRACE) && (tap.idx == lnec_pkg::POS_W'(cur - lnec_pkg::POS_W'(1)));
  assign push   = match;
  assign rd_sel = lnec_pkg::POS_W'(rdp - lnec_pkg::POS_W'(1));
  assign emit_done = res_valid && !res_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (accept && is_last) state_next = S_INIT;
      S_INIT:  state_next = S_PLOAD;
      S_PLOAD: state_next = S_PCMP;
      S_PCMP:  if (cyc == LAST_CYC) state_next = S_PUPD;
      S_PUPD:  state_next = (pass == lnec_pkg::POS_W'(count - lnec_pkg::POS_W'(1))) ?
                            S_FLOAD : S_PLOAD;
      S_FLOAD: state_next = S_FSCAN;
      S_FSCAN: if (cyc == LAST_CYC) state_next = (fin_len == '0) ? S_SHOW : S_TRACE;
      S_TRACE: if (match && tap.pred == '0) state_next = S_RD;
      S_RD:    state_next = S_SHOW;
      S_SHOW:  if (emit_done) state_next = last_of_run ? S_LOAD : S_RD;
      default: state_next = S_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      loaded_count <= '0;
      card_width   <= '0;
      card_height  <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == lnec_pkg::REG_CARD_W) card_width <= cfg_data;
        if (cfg_index == lnec_pkg::REG_CARD_H) card_height <= cfg_data;
      end
      if (accept) begin
        loaded_count <= is_last ? '0 :
                        (store_ok ? lnec_pkg::POS_W'(loaded_count + lnec_pkg::POS_W'(1))
                                  : loaded_count);
      end
      // Raise a result when one is ready, drop it when taken
      if ((state == S_FSCAN && cyc == LAST_CYC && fin_len == '0) || state == S_RD) begin
        res_valid <= 1'b1;
      end else if (emit_done) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      count <= store_ok ? lnec_pkg::POS_W'(loaded_count + lnec_pkg::POS_W'(1)) : loaded_count;
    end
    if (state == S_INIT) pass <= '0;
    if (state == S_PUPD) pass <= lnec_pkg::POS_W'(pass + lnec_pkg::POS_W'(1));
    if (state == S_PLOAD || state == S_FLOAD) begin
      cyc <= '0;
    end else begin
      cyc <= lnec_pkg::POS_W'(cyc + lnec_pkg::POS_W'(1));
    end
    if (state == S_FLOAD) begin
      bl <= '0;
    end else if (state == S_FSCAN && take) begin
      bl   <= tap.len;
      bkey <= {tap.w, tap.h, tap.idx};
    end
    if (state == S_FSCAN && cyc == LAST_CYC) begin
      cur               <= lnec_pkg::POS_W'(fin_idx + lnec_pkg::POS_W'(1));
      sp                <= '0;
      chain_length      <= '0;
      envelope_position <= '0;
      last_of_run       <= 1'b1;
    end
    if (push) begin
      sp  <= lnec_pkg::POS_W'(sp + lnec_pkg::POS_W'(1));
      cur <= tap.pred;
      if (tap.pred == '0) begin
        rdp   <= lnec_pkg::POS_W'(sp + lnec_pkg::POS_W'(1));
        total <= lnec_pkg::POS_W'(sp + lnec_pkg::POS_W'(1));
      end
    end
    if (state == S_RD) begin
      rdp <= rd_sel;
      envelope_position <= stack[rd_sel[AW-1:0]];
      chain_length      <= total;
      last_of_run       <= (rd_sel == '0);
    end
  end

  // Member stack, pushed from the chain end, read back from the start
  always_ff @(posedge clk) begin
    if (push) stack[sp[AW-1:0]] <= cur;
    rdata <= stack[rd_sel[AW-1:0]];
  end

  `LNEC_ASSERT_IMPL(a_no_load_while_result, res_valid, env_stall, "input taken during output")
  `LNEC_ASSERT_IMPL(a_stack_bound, state == S_TRACE, sp < FULL, "member stack overflow")
  `LNEC_ASSERT_IMPL(a_empty_form, res_valid && chain_length == '0,
    last_of_run && envelope_position == '0, "malformed empty result")
  `LNEC_ASSERT_IMPL(a_read_match, state == S_SHOW && res_valid && chain_length != '0,
    envelope_position == rdata || $past(state) != S_RD, "stack read mismatch")

endmodule

### tb/longest_nested_envelope_chain_top_test.sv
// Self-checking testbench for the longest nested envelope chain block.
module longest_nested_envelope_chain_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_W = lnec_pkg::DIM_W;
  localparam int POS_W = lnec_pkg::POS_W;
  localparam int SLOTS = 64;
  localparam logic [DIM_W-1:0] DIM_MAX = '1;

  typedef struct {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             last;
  } envelope_t;

  typedef struct {
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos;
    logic             last;
  } chain_member_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = lnec_pkg::REG_CARD_W;
  logic [DIM_W-1:0] cfg_data = '0;
  logic env_valid = 1'b0;
  logic env_stall;
  logic [DIM_W-1:0] env_width = '0;
  logic [DIM_W-1:0] env_height = '0;
  logic is_last = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [POS_W-1:0] chain_length;
  logic [POS_W-1:0] envelope_position;
  logic last_of_run;

  longest_nested_envelope_chain_top #(.MAX_ITEMS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .env_valid(env_valid), .env_stall(env_stall),
    .env_width(env_width), .env_height(env_height), .is_last(is_last),
    .res_valid(res_valid), .res_stall(res_stall),
    .chain_length(chain_length), .envelope_position(envelope_position),
    .last_of_run(last_of_run)
  );

  envelope_t     pending_envelopes[$];
  chain_member_t expected_members[$];

  // Shadow state of the block
  logic [DIM_W-1:0] card_w, card_h;
  logic [DIM_W-1:0] held_w[SLOTS];
  logic [DIM_W-1:0] held_h[SLOTS];
  int held_count;

  int mismatches = 0;
  int envelopes_sent = 0;
  int members_seen = 0;
  int sets_closed = 0;
  int empty_runs = 0;
  bit env_fire_q = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // True when held envelope a is processed ahead of held envelope b
  function automatic bit ahead_of(int a, int b);
    if (held_w[a] != held_w[b]) return held_w[a] < held_w[b];
    if (held_h[a] != held_h[b]) return held_h[a] < held_h[b];
    return a < b;
  endfunction

  // Store an envelope; on the closing one, solve the chain and queue its members
  task automatic absorb_envelope(input envelope_t e);
    int order[SLOTS];
    int clen[SLOTS];
    int cpred[SLOTS];
    int path[$];
    int n, i, j, k, best, best_end, now, pred, cur;
    chain_member_t m;
    if (held_count < SLOTS) begin
      held_w[held_count] = e.w;
      held_h[held_count] = e.h;
      held_count++;
    end
    if (!e.last) return;
    n = held_count;
    for (i = 0; i < n; i++) begin
      k = i;
      while (k > 0 && ahead_of(i, order[k-1])) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
    end
    best = 0;
    best_end = 0;
    for (i = 0; i < n; i++) begin
      clen[order[i]] = 0;
      cpred[order[i]] = 0;
      if (!(held_w[order[i]] > card_w && held_h[order[i]] > card_h)) continue;
      now = 0;
      pred = 0;
      for (j = 0; j < i; j++) begin
        if (clen[order[j]] > now && held_w[order[i]] > held_w[order[j]] &&
            held_h[order[i]] > held_h[order[j]]) begin
          now = clen[order[j]];
          pred = order[j] + 1;
        end
      end
      clen[order[i]] = now + 1;
      cpred[order[i]] = pred;
      if (now + 1 > best) begin
        best = now + 1;
        best_end = order[i];
      end
    end
    held_count = 0;
    sets_closed++;
    if (best == 0) begin
      m.len = '0;
      m.pos = '0;
      m.last = 1'b1;
      expected_members.push_back(m);
      empty_runs++;
      return;
    end
    cur = best_end + 1;
    while (cur != 0) begin
      path.push_front(cur);
      cur = cpred[cur-1];
    end
    foreach (path[p]) begin
      m.len = POS_W'(path.size());
      m.pos = POS_W'(path[p]);
      m.last = (p == path.size() - 1);
      expected_members.push_back(m);
    end
  endtask

  // Sample both handshakes, predict on accepted envelopes, check results
  always @(posedge clk) begin
    chain_member_t exp_m;
    env_fire_q <= !rst && env_valid && !env_stall;
    if (!rst && env_valid && !env_stall) begin
      envelope_t e;
      e.w = env_width;
      e.h = env_height;
      e.last = is_last;
      absorb_envelope(e);
    end
    if (!rst && res_valid && !res_stall) begin
      members_seen++;
      if (expected_members.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: len=%0d pos=%0d last=%0b",
                   chain_length, envelope_position, last_of_run);
      end else begin
        exp_m = expected_members.pop_front();
        if (chain_length !== exp_m.len || envelope_position !== exp_m.pos ||
            last_of_run !== exp_m.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp len=%0d pos=%0d last=%0b, got len=%0d pos=%0d last=%0b",
                     exp_m.len, exp_m.pos, exp_m.last,
                     chain_length, envelope_position, last_of_run);
        end
      end
    end
  end

  // Drive envelopes in bursts with random gaps; hold the payload while stalled
  always @(negedge clk) begin
    envelope_t e;
    if (!rst && (!env_valid || env_fire_q)) begin
      if (gap_left > 0) begin
        gap_left--;
        env_valid <= 1'b0;
      end else if (pending_envelopes.size() > 0) begin
        e = pending_envelopes.pop_front();
        env_width <= e.w;
        env_height <= e.h;
        is_last <= e.last;
        env_valid <= 1'b1;
        envelopes_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        env_valid <= 1'b0;
      end
    end
  end

  // Stall results in modes chosen at random, changed when a random timer runs out
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_timer = $urandom_range(50, 400);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 1) == 1);
      2: res_stall <= ($urandom_range(0, 9) < 8);
      default: res_stall <= (stall_timer % 7) < 3;
    endcase
  end

  task automatic push_env(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                          input logic last);
    envelope_t e;
    e.w = w;
    e.h = h;
    e.last = last;
    pending_envelopes.push_back(e);
  endtask

  // Wait until every envelope is taken and every member has come back
  task automatic wait_idle();
    while (pending_envelopes.size() > 0 || env_valid || expected_members.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_card(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lnec_pkg::REG_CARD_W;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= lnec_pkg::REG_CARD_H;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    card_w = w;
    card_h = h;
  endtask

  // Value near the card so that envelopes often fit and often tie
  function automatic logic [DIM_W-1:0] near_card(input logic [DIM_W-1:0] c);
    int unsigned v;
    v = (c > DIM_W'(8)) ? 32'(c) - 32'd8 : 32'd0;
    v = v + $urandom_range(0, 30);
    return (v > 32'(DIM_MAX)) ? DIM_MAX : DIM_W'(v);
  endfunction

  // One random set: clustered, fully random, or a shuffled nested chain
  task automatic random_set(output int count);
    int n, kind, i;
    envelope_t set_q[$];
    envelope_t e;
    kind = $urandom_range(0, 9);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 10);
    for (i = 0; i < n; i++) begin
      if (kind < 6) begin
        e.w = near_card(card_w);
        e.h = near_card(card_h);
      end else if (kind < 8) begin
        e.w = DIM_W'($urandom);
        e.h = DIM_W'($urandom);
      end else begin
        e.w = near_card(card_w) + DIM_W'(3 * i);
        e.h = near_card(card_h) + DIM_W'(3 * i);
      end
      e.last = 1'b0;
      set_q.push_back(e);
    end
    if (kind >= 8) set_q.shuffle();
    set_q[n-1].last = 1'b1;
    foreach (set_q[q]) pending_envelopes.push_back(set_q[q]);
    count = n;
  endtask

  task automatic random_phase(input int quota);
    int done, c;
    done = 0;
    while (done < quota) begin
      random_set(c);
      done += c;
    end
  endtask

  // Run stimulus by card setting
  initial begin
    envelope_t big_q[$];
    envelope_t e;
    int i;
    card_w = '0;
    card_h = '0;
    held_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_card('0, '0);
    // Directed: zero envelope, unit envelope, maxima, ties
    push_env('0, '0, 1'b1);
    push_env(20'd1, 20'd1, 1'b1);
    push_env(DIM_MAX, DIM_MAX, 1'b0);
    push_env(DIM_MAX, DIM_MAX, 1'b0);
    push_env(20'd1, 20'd1, 1'b1);
    push_env(20'd5, 20'd3, 1'b0);
    push_env(20'd5, 20'd7, 1'b0);
    push_env(20'd6, 20'd7, 1'b0);
    push_env(20'd7, 20'd8, 1'b0);
    push_env(20'd2, 20'd9, 1'b0);
    push_env(20'hAAAAA, 20'h55555, 1'b0);
    push_env(20'h55555, 20'hAAAAA, 1'b1);
    push_env(20'd0, DIM_MAX, 1'b0);
    push_env(DIM_MAX, 20'd0, 1'b1);
    wait_idle();

    // Full-length nested chain, then an overfull set whose tail is dropped
    for (i = 0; i < SLOTS; i++) begin
      e.w = DIM_W'(10 + 2 * i);
      e.h = DIM_W'(1000 + 5 * i);
      e.last = 1'b0;
      big_q.push_back(e);
    end
    big_q.shuffle();
    big_q[SLOTS-1].last = 1'b1;
    foreach (big_q[q]) pending_envelopes.push_back(big_q[q]);
    for (i = 0; i < SLOTS + 4; i++)
      push_env(DIM_W'($urandom_range(1, 60)), DIM_W'($urandom_range(1, 60)),
               i == SLOTS + 3);
    random_phase(60);
    wait_idle();

    write_card(DIM_MAX, DIM_MAX);
    push_env(DIM_MAX, DIM_MAX, 1'b1);
    random_phase(30);
    wait_idle();

    write_card(DIM_MAX - 1, 20'd16);
    push_env(DIM_MAX, 20'd17, 1'b0);
    push_env(DIM_MAX, 20'd16, 1'b1);
    random_phase(50);
    wait_idle();

    write_card(DIM_W'($urandom), DIM_W'($urandom_range(0, 4095)));
    random_phase(70);
    wait_idle();

    write_card(20'd100, DIM_MAX - 40);
    random_phase(50);
    wait_idle();

    write_card('0, '0);
    random_phase(50);
    wait_idle();

    repeat (200) @(posedge clk);
    $display("covered %0d envelopes in %0d sets, %0d chain members checked (%0d empty runs)",
             envelopes_sent, sets_closed, members_seen, empty_runs);
    if (mismatches == 0 && expected_members.size() == 0) begin
      $display("longest_nested_envelope_chain_top_test: done, clean");
    end else begin
      $display("%0d mismatches, %0d members still outstanding",
               mismatches, expected_members.size());
      $display("longest_nested_envelope_chain_top_test: done, errors");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #40ms;
    $display("timeout with %0d members outstanding", expected_members.size());
    $display("longest_nested_envelope_chain_top_test: done, errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/lnec_pkg.sv
hdl/lnec_cell.sv
hdl/longest_nested_envelope_chain_top.sv
tb/longest_nested_envelope_chain_top_test.sv
